/* hdl/msf_pkg.sv */
// Shared types, widths and helpers of the moving average speed filter.
// No dependencies; imported by every module of the block.
package msf_pkg;

  localparam int DISP_W  = 32;            // Q24.8 displacement and results
  localparam int STEP_W  = 16;            // Q8.8 time step
  localparam int ALPHA_W = 17;            // Q1.16 gain, one included
  localparam int SUM_W   = 40;            // running speed sum
  localparam int ERR_W   = 41;            // residual before scaling
  localparam int FILL_OUT_W = 5;

  localparam int MUL_A_W = 40;            // multiplicand magnitude
  localparam int MUL_B_W = 17;            // multiplier, one bit per cycle
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 40;            // dividend magnitude
  localparam int DIV_D_W = 16;            // divisor

  localparam int SAT_IN_W = 48;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h08000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_SPEED,
    ST_UPD,
    ST_ERR,
    ST_FILT,
    ST_OUT
  } msf_state_e;

  // window store commands from the sequencer
  typedef struct packed {
    logic rd;      // read oldest entry
    logic drop;    // retire oldest entry when full
    logic push;    // store new speed
    logic prime;   // restart window with one speed
  } win_cmd_t;

  // sign plus magnitude to saturated two's complement
  function automatic logic [DISP_W-1:0] sat_mag(input logic neg,
                                                input logic [SAT_IN_W-1:0] mag);
    logic [DISP_W-1:0] res;
    if (!neg) begin
      res = (mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[DISP_W-1:0];
    end else begin
      res = (mag > 48'h0000_8000_0000) ? 32'h8000_0000 : (~mag[DISP_W-1:0] + 32'd1);
    end
    return res;
  endfunction

endpackage

/* hdl/msf_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on msf_pkg.
module msf_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msf_pkg::MUL_A_W-1:0]   a_i,
  input  logic [msf_pkg::MUL_B_W-1:0]   b_i,
  output logic                          busy_o,
  output logic [msf_pkg::MUL_P_W-1:0]   p_o
);
  import msf_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_P_W-1:0] p_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [MUL_A_W:0]   acc;

  // add into the upper half, then shift the product right
  assign acc = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(MUL_B_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (cnt_q != '0) begin
      b_q <= {1'b0, b_q[MUL_B_W-1:1]};
      p_q <= {acc, p_q[MUL_B_W-1:1]};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign p_o    = p_q;

endmodule

/* hdl/msf_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on msf_pkg.
module msf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msf_pkg::DIV_N_W-1:0]   n_i,
  input  logic [msf_pkg::DIV_D_W-1:0]   d_i,
  output logic                          busy_o,
  output logic [msf_pkg::DIV_N_W-1:0]   q_o
);
  import msf_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] n_q;   // dividend bits out, quotient bits in
  logic [DIV_D_W-1:0] r_q;
  logic [DIV_D_W-1:0] d_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               fits;

  assign trial = {r_q, n_q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DIV_N_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      d_q <= d_i;
      r_q <= '0;
    end else if (cnt_q != '0) begin
      n_q <= {n_q[DIV_N_W-2:0], fits};
      r_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  assign busy_o = (cnt_q != '0);
  assign q_o    = n_q;

endmodule

/* hdl/msf_win.sv */
// Speed window: ring of the last WINDOW speeds, running sum and fill count.
// Depends on msf_pkg.
module msf_win #(
  parameter int WINDOW = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  msf_pkg::win_cmd_t                  cmd_i,
  input  logic [msf_pkg::DISP_W-1:0]         speed_i,
  output logic [msf_pkg::SUM_W-1:0]          sum_o,
  output logic [$clog2(WINDOW+1)-1:0]        fill_o
);
  import msf_pkg::*;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);

  logic [DISP_W-1:0] ring [WINDOW];
  logic [DISP_W-1:0] rd_q;
  logic [SUM_W-1:0]  sum_q;
  logic [FILL_W-1:0] fill_q;
  logic [IDX_W-1:0]  old_q;
  logic [IDX_W-1:0]  new_q;
  logic [IDX_W-1:0]  old_nxt;
  logic [IDX_W-1:0]  new_nxt;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic              full;
  logic [SUM_W-1:0]  rd_ext;
  logic [SUM_W-1:0]  speed_ext;

  assign full      = (fill_q == FILL_W'(WINDOW));
  assign old_nxt   = (old_q == IDX_W'(WINDOW - 1)) ? '0 : old_q + 1'b1;
  assign new_nxt   = (new_q == IDX_W'(WINDOW - 1)) ? '0 : new_q + 1'b1;
  assign wr_en     = cmd_i.prime | cmd_i.push;
  assign wr_addr   = cmd_i.prime ? '0 : new_nxt;
  assign rd_ext    = {{(SUM_W-DISP_W){rd_q[DISP_W-1]}}, rd_q};
  assign speed_ext = {{(SUM_W-DISP_W){speed_i[DISP_W-1]}}, speed_i};

  // ring storage, registered read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= ring[old_q];
    end
    if (wr_en) begin
      ring[wr_addr] <= speed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      old_q  <= '0;
      new_q  <= '0;
    end else if (cmd_i.prime) begin
      sum_q  <= speed_ext;
      fill_q <= FILL_W'(1);
      old_q  <= '0;
      new_q  <= '0;
    end else if (cmd_i.drop) begin
      if (full) begin
        sum_q <= sum_q - rd_ext;
        old_q <= old_nxt;
      end
    end else if (cmd_i.push) begin
      sum_q <= sum_q + speed_ext;
      new_q <= new_nxt;
      if (!full) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

/* hdl/moving_average_speed_filter_unit.sv */
// Moving average speed filter: top level with the item sequencer.
// Depends on msf_pkg, msf_mul, msf_div and msf_win.
//
// Each input transaction (displacement Q24.8, time step Q8.8) yields exactly
// one output transaction: the filtered displacement residual, the window
// average speed and the window fill. A zero time step counts as the smallest
// step. The first transaction after reset only primes the window: residual 0,
// average equal to its own speed. Later ones form
//   residual = (1 - alpha) * (residual + step * average - displacement)
// and push the new speed into a WINDOW-deep ring with a running sum; when the
// ring is full the oldest speed is retired. Every quotient truncates toward
// zero and every result saturates to signed 32 bits. All multiplication
// and division runs through one shared bit-serial shift-add multiplier
// and one shared restoring divider (one quotient bit per cycle). The speed
// division and the step*average product run side by side, then the residual
// scaling and the sum/fill division run side by side. One item is in work at
// a time, but the next one is accepted while a finished result still waits
// in the output register. The speed ring has no reset or clearing pass; only
// written entries ever reach the running sum. alpha is to be written only
// while idle, by the user; the block itself does not enforce it. Values
// above one act as one.
module moving_average_speed_filter_unit #(
  parameter int WINDOW = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: alpha, unsigned Q1.16
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] displacement, [47:32] time_step
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [31:0] filtered_displacement,
                                      // [63:32] average_speed,
                                      // [68:64] window_fill, [71:69] zero
);
  import msf_pkg::*;

  localparam int FILL_W = $clog2(WINDOW + 1);

  msf_state_e state_q, state_d;

  logic [ALPHA_W-1:0] alpha_q;
  logic [ALPHA_W-1:0] alpha_lim;
  logic [ALPHA_W-1:0] one_minus;

  logic [DISP_W-1:0]  disp_q;
  logic [DISP_W-1:0]  speed_q;
  logic [DISP_W-1:0]  filt_q;      // filtered residual state
  logic [DISP_W-1:0]  avg_q;       // average speed state
  logic [ERR_W-1:0]   fd_q;        // residual minus displacement
  logic [ERR_W-1:0]   err_q;

  logic               m_valid_q;
  logic [DISP_W-1:0]  out_filt_q;
  logic [DISP_W-1:0]  out_avg_q;
  logic [FILL_OUT_W-1:0] out_fill_q;

  logic [DISP_W-1:0]  in_disp;
  logic [STEP_W-1:0]  in_step;
  logic [STEP_W-1:0]  step_eff;
  logic [DISP_W-1:0]  disp_abs;
  logic [DISP_W-1:0]  avg_abs;
  logic [ERR_W-1:0]   err_abs;
  logic [SUM_W-1:0]   sum_abs;
  logic [SUM_W-1:0]   prod_mag;
  logic [ERR_W-1:0]   prod_s;

  logic               accept;
  logic               load_out;
  logic               units_idle;
  logic               fill_zero;
  logic [31:0]        fill_ext;

  logic               mul_start, mul_busy;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic               div_start, div_busy;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_N_W-1:0] div_q;

  win_cmd_t           win_cmd;
  logic [SUM_W-1:0]   win_sum;
  logic [FILL_W-1:0]  win_fill;

  // ---------------------------------------------------------------------------
  // input decode and operand shaping
  // ---------------------------------------------------------------------------
  assign in_disp  = s_axis_tdata[31:0];
  assign in_step  = s_axis_tdata[47:32];
  assign step_eff = (in_step == '0) ? STEP_W'(1) : in_step;

  assign disp_abs = in_disp[DISP_W-1] ? (~in_disp + 1'b1) : in_disp;
  assign avg_abs  = avg_q[DISP_W-1] ? (~avg_q + 1'b1) : avg_q;
  assign err_abs  = err_q[ERR_W-1] ? (~err_q + 1'b1) : err_q;
  assign sum_abs  = win_sum[SUM_W-1] ? (~win_sum + 1'b1) : win_sum;

  // step * |average| / 256, signed like the average (step is positive)
  assign prod_mag = mul_p[SUM_W+7:8];
  assign prod_s   = avg_q[DISP_W-1] ? (~{1'b0, prod_mag} + 1'b1) : {1'b0, prod_mag};

  assign alpha_lim = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign one_minus = ALPHA_ONE - alpha_lim;

  // first pair: speed division and step*average; second pair: residual
  // scaling and sum/fill division
  assign mul_a = (state_q == ST_IDLE) ? {{(MUL_A_W-DISP_W){1'b0}}, avg_abs}
                                      : err_abs[MUL_A_W-1:0];
  assign mul_b = (state_q == ST_IDLE) ? {1'b0, step_eff} : one_minus;
  assign div_n = (state_q == ST_IDLE) ? {disp_abs, 8'h00} : sum_abs;
  assign div_d = (state_q == ST_IDLE) ? step_eff : DIV_D_W'(win_fill);

  assign accept     = s_axis_tvalid & s_axis_tready;
  assign units_idle = !mul_busy && !div_busy;
  assign fill_zero  = (win_fill == '0);
  assign fill_ext   = 32'(win_fill);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    win_cmd       = '0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          win_cmd.rd = 1'b1;
          mul_start  = 1'b1;
          div_start  = 1'b1;
          state_d    = ST_DROP;
        end
      end
      ST_DROP: begin
        win_cmd.drop = 1'b1;
        state_d      = ST_SPEED;
      end
      ST_SPEED: begin
        if (units_idle) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (fill_zero) begin
          win_cmd.prime = 1'b1;
          state_d       = ST_OUT;
        end else begin
          win_cmd.push = 1'b1;
          state_d      = ST_ERR;
        end
      end
      ST_ERR: begin
        mul_start = 1'b1;
        div_start = 1'b1;
        state_d   = ST_FILT;
      end
      ST_FILT: begin
        if (units_idle) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // configuration and filter state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      filt_q  <= '0;
      avg_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (state_q == ST_UPD && fill_zero) begin
        filt_q <= '0;
        avg_q  <= speed_q;
      end else if (state_q == ST_FILT && units_idle) begin
        filt_q <= sat_mag(err_q[ERR_W-1], SAT_IN_W'(mul_p[MUL_P_W-1:16]));
        avg_q  <= sat_mag(win_sum[SUM_W-1], SAT_IN_W'(div_q));
      end
    end
  end

  // working registers of one item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      disp_q <= in_disp;
    end
    if (state_q == ST_DROP) begin
      fd_q <= {{(ERR_W-DISP_W){filt_q[DISP_W-1]}}, filt_q}
            - {{(ERR_W-DISP_W){disp_q[DISP_W-1]}}, disp_q};
    end
    if (state_q == ST_SPEED && units_idle) begin
      speed_q <= sat_mag(disp_q[DISP_W-1], SAT_IN_W'(div_q));
    end
    if (state_q == ST_UPD) begin
      err_q <= fd_q + prod_s;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_filt_q <= filt_q;
      out_avg_q  <= avg_q;
      out_fill_q <= fill_ext[FILL_OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, out_fill_q, out_avg_q, out_filt_q};

  // ---------------------------------------------------------------------------
  // units
  // ---------------------------------------------------------------------------
  msf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .p_o     (mul_p)
  );

  msf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .busy_o  (div_busy),
    .q_o     (div_q)
  );

  msf_win #(
    .WINDOW (WINDOW)
  ) u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (win_cmd),
    .speed_i (speed_q),
    .sum_o   (win_sum),
    .fill_o  (win_fill)
  );

`ifndef SYNTHESIS
  // a new transaction never lands on a unit still working on the last one
  a_accept_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> units_idle)
    else $error("input accepted while arithmetic units busy");

  // the divider is never started with a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (div_d != '0))
    else $error("division started by zero");

  // priming only on an empty window
  a_prime_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_cmd.prime |-> fill_zero)
    else $error("window primed while not empty");

  // fill count stays within the window depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_fill <= FILL_W'(WINDOW))
    else $error("window fill beyond depth");

  // a result appears only out of the result state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside result state");
`endif

endmodule

/* tb/sv/tb_moving_average_speed_filter_unit.sv */
// Self-checking testbench for moving_average_speed_filter_unit.
// Holds its own scoreboard class with an integer predictor of the filter.
// Depends on msf_pkg and the RTL of the block; reads no files.
module tb_moving_average_speed_filter_unit;
  import msf_pkg::*;

  localparam int SPEED_WINDOW = 16;   // matches the block's default WINDOW
  localparam int QUIET_LIMIT  = 5000; // cycles with no transaction on either side
  localparam int ITEMS_PER_PHASE = 240;
  localparam longint S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN  = -64'sh0000_0000_8000_0000;

  typedef struct {
    int          filt;
    int          avg;
    logic [4:0]  fill;
  } speed_result_t;

  // Predicts one result per accepted input transaction and checks results in order.
  class speed_filter_scoreboard;
    logic [ALPHA_W-1:0] alpha;
    int                 speed_hist[SPEED_WINDOW];
    longint             speed_total;
    int                 fill;
    int                 oldest;
    int                 newest;
    int                 resid;
    int                 avg_speed;
    speed_result_t      expected_q[$];
    int                 errors;

    function new();
      alpha       = ALPHA_RESET;
      speed_total = 0;
      fill        = 0;
      oldest      = 0;
      newest      = 0;
      resid       = 0;
      avg_speed   = 0;
      errors      = 0;
    endfunction

    function void set_alpha(logic [ALPHA_W-1:0] a);
      alpha = a;
    endfunction

    function int sat32(longint x);
      if (x > S32_MAX) return int'(S32_MAX);
      if (x < S32_MIN) return int'(S32_MIN);
      return int'(x);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic signed [31:0] disp, logic [15:0] step);
      longint        d;
      longint        st;
      longint        a;
      longint        one_minus;
      longint        err;
      int            speed;
      speed_result_t r;
      d  = disp;
      st = step;
      if (st == 0) st = 1;             // zero step acts as the smallest step
      speed = sat32((d * 256) / st);
      if (fill == 0) begin
        // priming transaction: window restarts with this speed
        oldest        = 0;
        newest        = 0;
        fill          = 1;
        speed_hist[0] = speed;
        speed_total   = speed;
        resid         = 0;
        avg_speed     = speed;
      end else begin
        a         = alpha;
        one_minus = 65536 - ((a > 65536) ? 65536 : a);   // alpha above one acts as one
        err       = longint'(resid) + (st * longint'(avg_speed)) / 256 - d;
        resid     = sat32((one_minus * err) / 65536);
        if (fill >= SPEED_WINDOW) begin
          // full window: retire the oldest speed first
          speed_total -= speed_hist[oldest];
          oldest       = (oldest + 1) % SPEED_WINDOW;
          fill         = SPEED_WINDOW;
        end else begin
          fill++;
        end
        newest             = (newest + 1) % SPEED_WINDOW;
        speed_hist[newest] = speed;
        speed_total       += speed;
        avg_speed          = sat32(speed_total / longint'(fill));
      end
      r.filt = resid;
      r.avg  = avg_speed;
      r.fill = fill[4:0];
      expected_q.push_back(r);
    endfunction

    function void mismatch(string field, longint exp_v, longint act_v);
      errors++;
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
    endfunction

    function void check_result(logic [71:0] data);
      speed_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result transaction with no expectation waiting");
        return;
      end
      e = expected_q.pop_front();
      if (int'(data[31:0]) != e.filt)
        mismatch("filtered_displacement", e.filt, $signed(data[31:0]));
      if (int'(data[63:32]) != e.avg)
        mismatch("average_speed", e.avg, $signed(data[63:32]));
      if (data[68:64] != e.fill)
        mismatch("window_fill", e.fill, data[68:64]);
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [16:0] cfg_wdata_i    = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata   = '0;   // [31:0] displacement, [47:32] time_step
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [71:0] m_axis_tdata;          // [31:0] filtered, [63:32] average, [68:64] fill

  speed_filter_scoreboard sb;
  bit  no_idle = 1'b0;   // set for the stretch where neither side idles
  int  stall_left = 0;
  int  quiet_cycles = 0;
  int  track = 0;        // running displacement of the smooth-motion stimulus

  moving_average_speed_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: short random stalls, now and then a long one.
  always @(posedge clk_i) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(999) == 0) begin
      stall_left = $urandom_range(1, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 16);
    end
  end

  // Both monitors sample the pre-edge values; input is noted before output is checked.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tdata[31:0], s_axis_tdata[47:32]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Holds tvalid high from one transaction to the next unless a gap is taken,
  // so tvalid never gets two assignments in one time step.
  task automatic send_item(input logic [31:0] disp, input logic [15:0] step);
    if (!no_idle && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {step, disp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender holds off until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_alpha(input logic [16:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_alpha(value);
  endtask

  task automatic directed_items();
    send_item(32'd2560, 16'd256);          // priming transaction
    send_item(32'd2560, 16'd256);
    send_item(32'd100, 16'd0);             // zero time step
    send_item(32'h7FFF_FFFF, 16'd1);       // speed saturates high
    send_item(32'h8000_0000, 16'd1);       // speed saturates low
    send_item(32'h7FFF_FFFF, 16'd65535);
    send_item(32'h8000_0000, 16'd65535);   // huge product
    send_item(32'h0000_0000, 16'd65535);
    send_item(32'hFFFF_FFFF, 16'd1);
    send_item(32'h0000_0001, 16'd0);
    send_item(32'hFFFF_FF00, 16'd256);
    send_item(32'h0000_0200, 16'd128);
    send_item(32'h0001_0000, 16'd512);
    send_item(32'hFFFE_0000, 16'd300);
    send_item(32'h0000_0000, 16'd1);
    send_item(32'h5555_5555, 16'hAAAA);    // window is full from here on
    send_item(32'hAAAA_AAAA, 16'h5555);
    send_item(32'h7FFF_FFFF, 16'd0);
    send_item(32'h8000_0000, 16'd0);
    send_item(32'h0000_0A00, 16'd256);
    send_item(32'h0000_0A00, 16'd256);
    send_item(32'h0000_0A00, 16'd65535);
  endtask

  // Mostly smooth motion near unit steps, with noise and extreme transactions mixed in.
  task automatic random_items(input int count);
    logic [31:0] disp;
    logic [15:0] step;
    int          delta;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        7: begin
          disp = $urandom;
          step = 16'($urandom_range(0, 65535));
        end
        8: begin
          case ($urandom_range(4))
            0: disp = 32'h7FFF_FFFF;
            1: disp = 32'h8000_0000;
            2: disp = 32'h0000_0000;
            3: disp = 32'hFFFF_FFFF;
            default: disp = $urandom;
          endcase
          case ($urandom_range(3))
            0: step = 16'd0;
            1: step = 16'd1;
            2: step = 16'hFFFF;
            default: step = 16'($urandom_range(0, 65535));
          endcase
        end
        9: begin
          disp = $urandom;
          step = 16'($urandom_range(0, 3));  // tiny steps push speeds into saturation
        end
        default: begin
          if ($urandom_range(49) == 0) track = int'($urandom_range(0, 1 << 22)) - (1 << 21);
          delta = $urandom_range(0, 511);
          track = track + delta - 256;
          delta = $urandom_range(0, 2047);
          disp  = track + delta - 1024;
          step  = 16'($urandom_range(192, 320));
        end
      endcase
      send_item(disp, step);
    end
  endtask

  initial begin
    logic [16:0] alpha_plan[8];
    sb = new();
    alpha_plan = '{17'd0, 17'h10000, 17'h1FFFF, 17'h10001, 17'd1, 17'h0C000, 17'd0, 17'h08000};
    alpha_plan[6] = 17'($urandom_range(0, 131071));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value of alpha covers the directed part
    directed_items();
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      write_alpha(alpha_plan[ph]);
      no_idle = (ph == 3);
      if (ph == 1) begin
        random_items(ITEMS_PER_PHASE / 2);
        drain_results();
        random_items(ITEMS_PER_PHASE / 2);
      end else begin
        random_items(ITEMS_PER_PHASE);
      end
      drain_results();
    end
    no_idle = 1'b0;

    // let any stray result show up before the verdict
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
